// ===== hdl/jtok_pkg.sv =====
// ----------------------------------------------------------------------------
// jtok_pkg
// Shared types and constants for the JSON tokenizer.
// ----------------------------------------------------------------------------
package jtok_pkg;

	// scan modes
	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_SLASH = 4'd1;
	localparam logic [3:0] M_LCOM  = 4'd2;
	localparam logic [3:0] M_BCOM  = 4'd3;
	localparam logic [3:0] M_BSTAR = 4'd4;
	localparam logic [3:0] M_STR   = 4'd5;
	localparam logic [3:0] M_ESC   = 4'd6;
	localparam logic [3:0] M_HEX   = 4'd7;
	localparam logic [3:0] M_KW    = 4'd8;
	localparam logic [3:0] M_NSIGN = 4'd9;
	localparam logic [3:0] M_NZERO = 4'd10;
	localparam logic [3:0] M_NINT  = 4'd11;
	localparam logic [3:0] M_NDOT  = 4'd12;
	localparam logic [3:0] M_NFRAC = 4'd13;

	// token kinds
	localparam logic [3:0] K_END   = 4'd0;
	localparam logic [3:0] K_LBRC  = 4'd1;
	localparam logic [3:0] K_RBRC  = 4'd2;
	localparam logic [3:0] K_LBRK  = 4'd3;
	localparam logic [3:0] K_RBRK  = 4'd4;
	localparam logic [3:0] K_COMMA = 4'd5;
	localparam logic [3:0] K_COLON = 4'd6;
	localparam logic [3:0] K_STR   = 4'd7;
	localparam logic [3:0] K_NUM   = 4'd8;
	localparam logic [3:0] K_TRUE  = 4'd9;

	// error codes
	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_CHAR    = 3'd1;
	localparam logic [2:0] E_ESC     = 3'd2;
	localparam logic [2:0] E_OPEN    = 3'd3;
	localparam logic [2:0] E_UNI     = 3'd4;
	localparam logic [2:0] E_KW      = 3'd5;
	localparam logic [2:0] E_LZERO   = 3'd6;
	localparam logic [2:0] E_NOFRAC  = 3'd7;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// one result as seen at the output
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic        has;
		logic [7:0]  value;
		logic        done;
		logic [2:0]  err;
		logic        last;
	} result_t;

	// expected keyword letter at a given offset
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			2'd0: begin
				case (i)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			2'd1: begin
				case (i)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			default: begin
				case (i)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		return (k == 2'd1) ? 3'd5 : 3'd4;
	endfunction

endpackage

// ===== hdl/jtok_out_buf.sv =====
// ----------------------------------------------------------------------------
// jtok_out_buf
// Four-entry result queue; decouples the scanner from output stalls.
// ----------------------------------------------------------------------------
module jtok_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               push_two,
	input  jtok_pkg::result_t  din0,
	input  jtok_pkg::result_t  din1,
	output logic               space_two,
	output logic               out_valid,
	input  logic               out_ready,
	output jtok_pkg::result_t  dout
);
	import jtok_pkg::*;

	result_t     mem_q [4];
	logic [1:0]  rd_q;
	logic [1:0]  wr_q;
	logic [2:0]  cnt_q;
	logic [2:0]  cnt_next;
	logic        pop;
	logic [2:0]  n_push;

	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_q];
	assign n_push    = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;
	assign cnt_next  = cnt_q + n_push - {2'b00, pop};
	// room for two more once this cycle's push and pop are done
	assign space_two = (cnt_next <= 3'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din0;
			if (push_two)
				mem_q[wr_q + 2'd1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 2'd0;
			wr_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + n_push[1:0];
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_next;
		end
	end
endmodule

// ===== hdl/json_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// json_tokenizer_top
// Streaming JSON lexer, one text byte per transfer.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with req_type (0 text byte, 1 end of input)
// and in_byte. Output channel: out_valid/out_ready, one result per transfer;
// one input causes zero, one or two results, the last flagged last_of_run.
// The scanner registers the input, decodes it in the next cycle and writes its
// results into a four-entry queue, from which the outputs are driven. One input
// per cycle is taken while the queue, counting this cycle's push and pop, holds
// at most two results; the second result of one input leaves in its own output
// transfer.
// When the receiver stalls, the queue fills and in_ready drops.
// Reset puts the scanner between tokens at line 1, column 1 with no error
// and empties the queue. After an error no further results come until reset;
// an end token returns the scanner to its reset state.
// ----------------------------------------------------------------------------
module json_tokenizer_top #(
	parameter int POS_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [7:0]           in_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           token_kind,
	output logic [15:0]          token_line,
	output logic [15:0]          token_column,
	output logic                 has_byte,
	output logic [7:0]           value_byte,
	output logic                 token_done,
	output logic [2:0]           error_code,
	output logic                 last_of_run
);
	import jtok_pkg::*;

	localparam logic [POS_BITS-1:0] PMAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] PONE = {{(POS_BITS-1){1'b0}}, 1'b1};

	// input register
	logic        v_s1;
	logic        type_s1;
	logic [7:0]  byte_s1;

	// scanner state
	logic [3:0]          mode_q;
	logic [2:0]          sub_q;
	logic [1:0]          kw_q;
	logic [15:0]         hex_q;
	logic [POS_BITS-1:0] cl_q, cc_q, tl_q, tc_q;
	logic                err_q;

	logic space_two;
	logic accept;

	assign in_ready = space_two;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req_type;
			byte_s1 <= in_byte;
		end
	end

	function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
		logic [15:0] r;
		if (POS_BITS > 16 && (v >> 16) != '0)
			r = 16'hFFFF;
		else
			r = 16'(v);
		return r;
	endfunction

	// next state and results
	logic [3:0]          m_n;
	logic [2:0]          sub_n;
	logic [1:0]          kw_n;
	logic [15:0]         hex_n;
	logic [POS_BITS-1:0] cl_n, cc_n, tl_n, tc_n;
	logic                err_n;
	result_t             r0, r1;
	logic [1:0]          nres;

	always_comb begin
		logic [7:0]  b;
		logic        dig;
		logic [4:0]  hv;
		logic [3:0]  scan;
		logic        rescan;
		logic [2:0]  sc;
		logic [7:0]  ev;
		logic        fail;
		logic [3:0]  fk;
		logic [2:0]  fe;
		logic [POS_BITS-1:0] fl, fc;
		logic [3:0]  kk;
		result_t     rs;
		logic        rs_v;
		result_t     rn;
		logic        rn_v;

		b      = byte_s1;
		dig    = (b >= "0") && (b <= "9");
		m_n    = mode_q;
		sub_n  = sub_q;
		kw_n   = kw_q;
		hex_n  = hex_q;
		cl_n   = cl_q;
		cc_n   = cc_q;
		tl_n   = tl_q;
		tc_n   = tc_q;
		err_n  = err_q;
		rescan = 1'b0;
		fail   = 1'b0;
		fk     = K_END;
		fe     = E_NONE;
		fl     = tl_q;
		fc     = tc_q;
		kk     = K_TRUE + {2'b00, kw_q};
		rn     = '0;
		rn_v   = 1'b0;
		rs     = '0;
		rs_v   = 1'b0;
		ev     = 8'h00;
		sc     = 3'd0;
		hv     = 5'h10;
		scan   = M_IDLE;
		if (b >= "0" && b <= "9") hv = {1'b0, 4'(b - "0")};
		else if (b >= "a" && b <= "f") hv = {1'b0, 4'(b - "a" + 8'd10)};
		else if (b >= "A" && b <= "F") hv = {1'b0, 4'(b - "A" + 8'd10)};

		rn.line   = sat16(tl_q);
		rn.column = sat16(tc_q);

		if (type_s1 == REQ_END) begin
			case (mode_q)
				M_SLASH: begin fail = 1'b1; fk = K_END; fe = E_CHAR; end
				M_STR, M_ESC: begin fail = 1'b1; fk = K_STR; fe = E_OPEN; end
				M_HEX: begin fail = 1'b1; fk = K_STR; fe = E_UNI; end
				M_KW: begin fail = 1'b1; fk = kk; fe = E_KW; end
				M_NDOT: begin
					fail = 1'b1; fk = K_NUM; fe = E_NOFRAC; fl = cl_q; fc = cc_q;
				end
				M_NSIGN, M_NZERO, M_NINT, M_NFRAC: begin
					rn_v = 1'b1; rn.kind = K_NUM; rn.done = 1'b1;
				end
				default: ;
			endcase
			if (!fail) begin
				rs_v = 1'b1;
				rs.kind = K_END; rs.line = sat16(cl_q); rs.column = sat16(cc_q);
				rs.done = 1'b1;
				m_n = M_IDLE; sub_n = 3'd0; kw_n = 2'd0; hex_n = 16'd0;
				cl_n = PONE; cc_n = PONE; tl_n = PONE; tc_n = PONE;
			end
		end else begin
			case (mode_q)
				M_SLASH: begin
					if (b == "/") m_n = M_LCOM;
					else if (b == "*") m_n = M_BCOM;
					else begin fail = 1'b1; fk = K_END; fe = E_CHAR; end
				end
				M_LCOM: if (b == 8'h0A) m_n = M_IDLE;
				M_BCOM: if (b == "*") m_n = M_BSTAR;
				M_BSTAR: begin
					if (b == "/") m_n = M_IDLE;
					else if (b != "*") m_n = M_BCOM;
				end
				M_STR: begin
					rn.kind = K_STR;
					if (b == "\\") m_n = M_ESC;
					else if (b == "\"") begin
						rn_v = 1'b1; rn.done = 1'b1; m_n = M_IDLE;
					end else begin
						rn_v = 1'b1; rn.has = 1'b1; rn.value = b;
					end
				end
				M_ESC: begin
					m_n = M_STR;
					rn.kind = K_STR;
					rn.has  = 1'b1;
					rn_v    = 1'b1;
					case (b)
						"\"", "\\", "/": ev = b;
						"b": ev = 8'd8;
						"f": ev = 8'd12;
						"n": ev = 8'd10;
						"r": ev = 8'd13;
						"t": ev = 8'd9;
						"u": begin
							rn_v = 1'b0; m_n = M_HEX; sub_n = 3'd0; hex_n = 16'd0;
						end
						default: begin
							rn_v = 1'b0; fail = 1'b1; fk = K_STR; fe = E_ESC;
						end
					endcase
					rn.value = ev;
				end
				M_HEX: begin
					if (hv[4]) begin
						fail = 1'b1; fk = K_STR; fe = E_UNI;
					end else begin
						hex_n = {hex_q[11:0], hv[3:0]};
						sc    = sub_q + 3'd1;
						sub_n = sc;
						if (sc >= 3'd4) begin
							rn_v = 1'b1; rn.kind = K_STR; rn.has = 1'b1;
							rn.value = hex_n[7:0];
							m_n = M_STR; sub_n = 3'd0;
						end
					end
				end
				M_KW: begin
					if (sub_q < kw_len(kw_q) && b == kw_char(kw_q, sub_q)) begin
						sc = sub_q + 3'd1;
						sub_n = sc;
						rn_v = 1'b1; rn.kind = kk; rn.has = 1'b1; rn.value = b;
						if (sc >= kw_len(kw_q)) begin
							rn.done = 1'b1; m_n = M_IDLE; sub_n = 3'd0;
						end
					end else begin
						fail = 1'b1; fk = kk; fe = E_KW;
					end
				end
				M_NSIGN, M_NZERO, M_NINT, M_NDOT, M_NFRAC: begin
					rn.kind = K_NUM;
					if (mode_q == M_NDOT) begin
						if (dig) begin
							m_n = M_NFRAC; rn_v = 1'b1; rn.has = 1'b1; rn.value = b;
						end else begin
							fail = 1'b1; fk = K_NUM; fe = E_NOFRAC; fl = cl_q; fc = cc_q;
						end
					end else if (mode_q == M_NZERO && dig) begin
						fail = 1'b1; fk = K_NUM; fe = E_LZERO;
					end else if (dig) begin
						if (mode_q == M_NSIGN) m_n = (b == "0") ? M_NZERO : M_NINT;
						rn_v = 1'b1; rn.has = 1'b1; rn.value = b;
					end else if (b == "." && mode_q != M_NFRAC) begin
						m_n = M_NDOT; rn_v = 1'b1; rn.has = 1'b1; rn.value = b;
					end else begin
						rn_v = 1'b1; rn.done = 1'b1; m_n = M_IDLE; rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase

			// token start from the idle state or after a number ends
			if (rescan) begin
				scan = M_IDLE;
				tl_n = cl_q;
				tc_n = cc_q;
				rs.line   = sat16(cl_q);
				rs.column = sat16(cc_q);
				rs.has    = 1'b1;
				rs.value  = b;
				case (b)
					8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: ;
					"{": begin rs_v = 1'b1; rs.kind = K_LBRC; rs.done = 1'b1; end
					"}": begin rs_v = 1'b1; rs.kind = K_RBRC; rs.done = 1'b1; end
					"[": begin rs_v = 1'b1; rs.kind = K_LBRK; rs.done = 1'b1; end
					"]": begin rs_v = 1'b1; rs.kind = K_RBRK; rs.done = 1'b1; end
					",": begin rs_v = 1'b1; rs.kind = K_COMMA; rs.done = 1'b1; end
					":": begin rs_v = 1'b1; rs.kind = K_COLON; rs.done = 1'b1; end
					"/": scan = M_SLASH;
					"\"": scan = M_STR;
					"t", "f", "n": begin
						kw_n  = (b == "t") ? 2'd0 : ((b == "f") ? 2'd1 : 2'd2);
						sub_n = 3'd1;
						scan  = M_KW;
						rs_v  = 1'b1;
						rs.kind = K_TRUE + {2'b00, kw_n};
					end
					"-": begin scan = M_NSIGN; rs_v = 1'b1; rs.kind = K_NUM; end
					"0": begin scan = M_NZERO; rs_v = 1'b1; rs.kind = K_NUM; end
					default: begin
						if (dig) begin
							scan = M_NINT; rs_v = 1'b1; rs.kind = K_NUM;
						end else begin
							fail = 1'b1; fk = K_END; fe = E_CHAR; fl = cl_q; fc = cc_q;
						end
					end
				endcase
				m_n = scan;
			end

			if (b == 8'h0A) begin
				cl_n = (cl_q == PMAX) ? PMAX : cl_q + PONE;
				cc_n = PONE;
			end else begin
				cc_n = (cc_q == PMAX) ? PMAX : cc_q + PONE;
			end
		end

		if (fail) begin
			rs = '0;
			rs_v = 1'b1;
			rs.kind = fk; rs.line = sat16(fl); rs.column = sat16(fc);
			rs.done = 1'b1; rs.err = fe;
			err_n = 1'b1;
			m_n = M_IDLE;
		end

		// pack: rn comes first when both exist
		r0 = rn_v ? rn : rs;
		r1 = rs;
		nres = {1'b0, rn_v} + {1'b0, rs_v};
		if (nres == 2'd2) r1.last = 1'b1;
		else r0.last = 1'b1;
	end

	logic run;
	assign run = v_s1 && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			sub_q  <= 3'd0;
			kw_q   <= 2'd0;
			hex_q  <= 16'd0;
			cl_q   <= PONE;
			cc_q   <= PONE;
			tl_q   <= PONE;
			tc_q   <= PONE;
			err_q  <= 1'b0;
		end else if (run) begin
			mode_q <= m_n;
			sub_q  <= sub_n;
			kw_q   <= kw_n;
			hex_q  <= hex_n;
			cl_q   <= cl_n;
			cc_q   <= cc_n;
			tl_q   <= tl_n;
			tc_q   <= tc_n;
			err_q  <= err_n;
		end
	end

	result_t dout;

	jtok_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (run && nres != 2'd0),
		.push_two  (nres == 2'd2),
		.din0      (r0),
		.din1      (r1),
		.space_two (space_two),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (dout)
	);

	assign token_kind   = dout.kind;
	assign token_line   = dout.line;
	assign token_column = dout.column;
	assign has_byte     = dout.has;
	assign value_byte   = dout.value;
	assign token_done   = dout.done;
	assign error_code   = dout.err;
	assign last_of_run  = dout.last;

`ifndef NO_ASSERTIONS
	// an error result always closes its token
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != E_NONE |-> token_done && !has_byte)
		else $error("error result without done");

	// sticky error: scanner state frozen afterwards
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q && $stable(mode_q))
		else $error("error state not sticky");

	// an input is only taken when the queue has room for two results
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> space_two)
		else $error("input taken without queue room");
`endif
endmodule
